// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and result codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Width of a block number on the ports.
  localparam int unsigned IDX_W = 19;
  // Width of the status field.
  localparam int unsigned STS_W = 2;

  localparam int unsigned DEF_NUM_BLOCKS      = 524288;
  localparam int unsigned DEF_WORD_BITS       = 32;
  localparam int unsigned DEF_RESERVED_BLOCKS = 2;
  localparam int unsigned DEF_MAP_WORDS       =
    (DEF_NUM_BLOCKS + DEF_WORD_BITS - 1) / DEF_WORD_BITS;
  localparam int unsigned DEF_AW              = $clog2(DEF_MAP_WORDS);
  localparam int unsigned DEF_PW              = $clog2(DEF_WORD_BITS);

  typedef enum logic [STS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2
  } status_e;

endpackage

// ===== src/bba_map_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_map_ram
// Free-map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram
  import bba_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned DEPTH     = DEF_MAP_WORDS,
  parameter int unsigned AW        = DEF_AW
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bba_first_free.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_first_free
// Finds the lowest free block in one map word (the highest set bit).
// ----------------------------------------------------------------------------
module bba_first_free
  import bba_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned PW        = DEF_PW
) (
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 found_o,
  output logic [PW-1:0]        pos_o
);

  always_comb begin
    pos_o = '0;
    // Higher bits override lower ones, so the highest set bit wins.
    for (int unsigned i = 0; i < WORD_BITS; i++) begin
      if (word_i[i]) begin
        pos_o = PW'(WORD_BITS - 1 - i);
      end
    end
  end

  assign found_o = |word_i;

endmodule

// ===== src/bitmap_block_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// Free-block allocator over a bitmap held in a single-port-pair memory.
//
// Requests arrive on the input channel (req_type_i, block_index_i); each
// request yields exactly one result beat (granted_block_o, status_o) on the
// output channel. One request is worked on at a time.
// Work per request, from accept to result valid:
//   free request            map read, then write back
//   refused or full request no map access
//   allocate                map read and write back of the word of the
//                           current hint, then an upward scan that reads each
//                           further word until a free block or the last word.
// A new request is taken only once the result of the last one is in the output register.
// After reset the block runs a clearing pass that writes every map word to
// all ones, one word per cycle (MAP_WORDS words, 16384 with the default
// parameters); in_ready_o stays low until it ends.
// The result sits in an output register. While the receiver stalls, the next
// request is still accepted and worked on; its result waits until the output
// register is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS      = DEF_NUM_BLOCKS,
  parameter int unsigned WORD_BITS       = DEF_WORD_BITS,
  parameter int unsigned RESERVED_BLOCKS = DEF_RESERVED_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] block_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] granted_block_o,
  output logic [STS_W-1:0] status_o
);

  localparam int unsigned MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW         = $clog2(WORD_BITS);
  localparam int unsigned LAST_VALID = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam int unsigned CW         = (AW + PW > IDX_W) ? AW + PW : IDX_W;
  // Block number to word address by reciprocal multiplication; exact for
  // every IDX_W-bit block number.
  localparam int unsigned DIV_SH     = IDX_W + PW;
  localparam int unsigned MW         = IDX_W + 2;
  localparam int unsigned PRW        = IDX_W + MW;
  localparam logic [MW-1:0] DIV_M    =
    MW'(((longint'(1) << DIV_SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS));

  localparam logic [IDX_W-1:0]     RSV_BLK   = IDX_W'(RESERVED_BLOCKS);
  localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ALL_ONES  = '1;
  // Bits of the last word that stand for blocks beyond the end are masked.
  localparam logic [WORD_BITS-1:0] LAST_MASK = ~(ALL_ONES >> LAST_VALID);
  localparam logic [PW-1:0]        TOP_BIT   = PW'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_WR,
    S_ALLOC_FIRST,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    clr_q;
  logic [AW-1:0]    word_q;
  logic [IDX_W-1:0] blk_q;
  logic [IDX_W-1:0] hint_blk_q;
  logic             all_used_q;
  logic [IDX_W-1:0] res_gnt_q;
  status_e          res_sts_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_gnt_q;
  status_e          out_sts_q;

  logic             accept;
  logic             is_free_req;
  logic             is_rsv;
  logic             is_oor;
  logic [IDX_W-1:0] div_in;
  logic [PRW-1:0]   div_prod;
  logic [AW-1:0]    div_word;
  logic [CW-1:0]    base_c;
  logic [PW-1:0]    pos_c;
  logic [WORD_BITS-1:0] pos_bit;
  logic [WORD_BITS-1:0] above_mask;
  logic [WORD_BITS-1:0] cand;
  logic             ff_found;
  logic [PW-1:0]    ff_pos;
  logic [IDX_W-1:0] new_hint;
  logic             scanning;
  logic             out_free;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_free_req = req_type_i;
  assign is_rsv      = block_index_i < RSV_BLK;
  assign is_oor      = 32'(block_index_i) >= NUM_BLOCKS;

  // Shared word-address unit: the freed block or the hinted block.
  assign div_in   = is_free_req ? block_index_i : hint_blk_q;
  assign div_prod = PRW'(div_in) * PRW'(DIV_M);
  assign div_word = AW'(div_prod >> DIV_SH);

  // Position of the held block inside its word.
  assign base_c     = CW'(word_q) * CW'(WORD_BITS);
  assign pos_c      = PW'(CW'(blk_q) - base_c);
  assign pos_bit    = {{(WORD_BITS-1){1'b0}}, 1'b1} << (TOP_BIT - pos_c);
  assign above_mask = ALL_ONES >> ({1'b0, pos_c} + (PW+1)'(1));

  assign scanning = (state_q == S_ALLOC_FIRST) || (state_q == S_SCAN);
  assign cand     = ram_rdata
                  & ((state_q == S_ALLOC_FIRST) ? above_mask : ALL_ONES)
                  & ((word_q == LAST_WORD) ? LAST_MASK : ALL_ONES);
  assign new_hint = IDX_W'(base_c + CW'(ff_pos));

  bba_first_free #(
    .WORD_BITS (WORD_BITS),
    .PW        (PW)
  ) u_first_free (
    .word_i  (cand),
    .found_o (ff_found),
    .pos_o   (ff_pos)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = ram_rdata | pos_bit;
    ram_re    = 1'b0;
    ram_raddr = AW'(word_q + AW'(1));
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = ALL_ONES;
      end
      S_IDLE: begin
        ram_raddr = div_word;
        ram_re    = accept && (is_free_req ? (!is_rsv && !is_oor) : !all_used_q);
      end
      S_FREE_WR: begin
        ram_we = 1'b1;
      end
      S_ALLOC_FIRST: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~pos_bit;
        ram_re    = !ff_found && (word_q != LAST_WORD);
      end
      S_SCAN: begin
        ram_re = !ff_found && (word_q != LAST_WORD);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  bba_map_ram #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (MAP_WORDS),
    .AW        (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      word_q      <= '0;
      blk_q       <= '0;
      hint_blk_q  <= RSV_BLK;
      all_used_q  <= 1'b0;
      res_gnt_q   <= '0;
      res_sts_q   <= ST_DONE;
      out_valid_q <= 1'b0;
      out_gnt_q   <= '0;
      out_sts_q   <= ST_DONE;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= AW'(clr_q + AW'(1));
          if (clr_q == LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            word_q    <= div_word;
            res_gnt_q <= '0;
            res_sts_q <= ST_DONE;
            if (is_free_req) begin
              blk_q <= block_index_i;
              if (is_rsv) begin
                res_sts_q <= ST_RESERVED;
                state_q   <= S_EMIT;
              end else if (is_oor) begin
                state_q <= S_EMIT;
              end else begin
                state_q <= S_FREE_WR;
              end
            end else begin
              blk_q <= hint_blk_q;
              if (all_used_q) begin
                res_sts_q <= ST_FULL;
                state_q   <= S_EMIT;
              end else begin
                state_q <= S_ALLOC_FIRST;
              end
            end
          end
        end
        S_FREE_WR: begin
          if (all_used_q) begin
            all_used_q <= 1'b0;
            hint_blk_q <= blk_q;
          end else if (blk_q < hint_blk_q) begin
            hint_blk_q <= blk_q;
          end
          state_q <= S_EMIT;
        end
        S_ALLOC_FIRST, S_SCAN: begin
          res_gnt_q <= blk_q;
          if (ff_found) begin
            hint_blk_q <= new_hint;
            state_q    <= S_EMIT;
          end else if (word_q == LAST_WORD) begin
            // The granted block was the last free one.
            all_used_q <= 1'b1;
            state_q    <= S_EMIT;
          end else begin
            word_q  <= AW'(word_q + AW'(1));
            state_q <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_gnt_q <= res_gnt_q;
            out_sts_q <= res_sts_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_gnt_q;
  assign status_o        = out_sts_q;

  // The write back of a word never meets a read of the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("map read and write collide on one word");

  // A result beat only appears out of the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result beat without a finished request");

  // Only a successful allocate carries a block number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (granted_block_o == '0))
    else $error("refused request carries a block number");

  // The hint never points at a reserved block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !all_used_q |-> ((NUM_BLOCKS > (1 << IDX_W)) || (hint_blk_q >= RSV_BLK)))
    else $error("hint points at a reserved block");

  // Scanning only happens with the map not yet exhausted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> !all_used_q)
    else $error("scan started while the map is full");

endmodule
